// ===== sv/nta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nta_pkg
// Shared types and constants of the nearest timestamp associator.
// ----------------------------------------------------------------------------
package nta_pkg;

  localparam int unsigned REF_DEPTH_DEF = 1024;
  localparam int unsigned STAMP_W       = 40;
  localparam int unsigned POS_W         = 32;
  localparam int unsigned GAP_W         = 24;
  localparam int unsigned ACT_W         = 2;
  localparam logic [GAP_W-1:0] MAX_GAP_RESET = 24'd100000;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic start;
    logic issue;
    logic emit;
  } nta_cmd_t;

  typedef struct packed {
    logic scan_more;
    logic pipe_busy;
    logic found;
    logic out_free;
  } nta_status_t;

endpackage
`default_nettype wire

// ===== sv/nta_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nta_ctrl
// Controller: accepts transactions and sequences the reference scan.
// ----------------------------------------------------------------------------
module nta_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [nta_pkg::ACT_W-1:0]         action,
  input  nta_pkg::nta_status_t              status,
  output nta_pkg::nta_cmd_t                 cmd
);
  import nta_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (action_t'(action))
            ACT_CLEAR: cmd.clear = 1'b1;
            ACT_LOAD:  cmd.load = 1'b1;
            ACT_QUERY: begin
              cmd.start  = 1'b1;
              state_next = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (status.scan_more) begin
          cmd.issue = 1'b1;
        end else begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = status.found ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> state == ST_SCAN && !in_ready)
    else $error("scan read outside scan state");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && !status.pipe_busy && !status.found) |=> state == ST_IDLE)
    else $error("missed query did not return to idle");

  assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == ST_SCAN)
    else $error("query start did not enter scan");

endmodule
`default_nettype wire

// ===== sv/nta_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nta_dp
// Datapath: reference store, scan pipeline, best-match tracking, result register.
// ----------------------------------------------------------------------------
module nta_dp #(
  parameter int unsigned REF_DEPTH = nta_pkg::REF_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  nta_pkg::nta_cmd_t                   cmd,
  output nta_pkg::nta_status_t                status,
  input  logic                                cfg_valid,
  input  logic [nta_pkg::GAP_W-1:0]           cfg_data,
  input  logic [nta_pkg::STAMP_W-1:0]         stamp,
  input  logic signed [nta_pkg::POS_W-1:0]    pos_x,
  input  logic signed [nta_pkg::POS_W-1:0]    pos_y,
  input  logic signed [nta_pkg::POS_W-1:0]    pos_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [nta_pkg::STAMP_W-1:0]         ref_stamp,
  output logic signed [nta_pkg::POS_W-1:0]    ref_x,
  output logic signed [nta_pkg::POS_W-1:0]    ref_y,
  output logic signed [nta_pkg::POS_W-1:0]    ref_z,
  output logic [nta_pkg::STAMP_W-1:0]         query_stamp,
  output logic signed [nta_pkg::POS_W-1:0]    query_x,
  output logic signed [nta_pkg::POS_W-1:0]    query_y,
  output logic signed [nta_pkg::POS_W-1:0]    query_z
);
  import nta_pkg::*;

  localparam int unsigned ADDR_W  = $clog2(REF_DEPTH);
  localparam int unsigned CNT_W   = $clog2(REF_DEPTH + 1);
  localparam int unsigned ENTRY_W = STAMP_W + 3 * POS_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(REF_DEPTH);

  logic [ENTRY_W-1:0] mem [REF_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] cmp_data;
  logic [ENTRY_W-1:0] best_data;
  logic [CNT_W-1:0]   ref_count;
  logic [CNT_W-1:0]   scan_idx;
  logic [GAP_W-1:0]   max_gap;
  logic [GAP_W-1:0]   best_gap;
  logic [STAMP_W-1:0] gap;
  logic [STAMP_W-1:0] q_stamp;
  logic [POS_W-1:0]   q_x;
  logic [POS_W-1:0]   q_y;
  logic [POS_W-1:0]   q_z;
  logic [STAMP_W-1:0] rd_time;
  logic               rd_vld;
  logic               cmp_vld;
  logic               found;
  logic               in_range;
  logic               better;

  assign rd_time  = rd_data[ENTRY_W-1 -: STAMP_W];
  assign in_range = (gap[STAMP_W-1:GAP_W] == '0) && (gap[GAP_W-1:0] < max_gap);
  assign better   = !found || (gap[GAP_W-1:0] < best_gap);

  assign status.scan_more = scan_idx < ref_count;
  assign status.pipe_busy = rd_vld || cmp_vld;
  assign status.found     = found;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap <= MAX_GAP_RESET;
    end else if (cfg_valid) begin
      max_gap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && ref_count < DEPTH_CNT) begin
      mem[ref_count[ADDR_W-1:0]] <= {stamp, pos_x, pos_y, pos_z};
    end
    if (cmd.issue) begin
      rd_data <= mem[scan_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
    end else if (cmd.clear) begin
      ref_count <= '0;
    end else if (cmd.load && ref_count < DEPTH_CNT) begin
      ref_count <= ref_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_stamp <= stamp;
      q_x     <= pos_x;
      q_y     <= pos_y;
      q_z     <= pos_z;
    end
    if (cmd.start) begin
      scan_idx <= '0;
    end else if (cmd.issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (rd_vld) begin
      gap      <= (q_stamp >= rd_time) ? q_stamp - rd_time : rd_time - q_stamp;
      cmp_data <= rd_data;
    end
    if (cmp_vld && in_range && better) begin
      best_gap  <= gap[GAP_W-1:0];
      best_data <= cmp_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      cmp_vld <= 1'b0;
      found   <= 1'b0;
    end else begin
      rd_vld  <= cmd.issue;
      cmp_vld <= rd_vld;
      if (cmd.start) begin
        found <= 1'b0;
      end else if (cmp_vld && in_range) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      {ref_stamp, ref_x, ref_y, ref_z} <= best_data;
      query_stamp <= q_stamp;
      query_x     <= q_x;
      query_y     <= q_y;
      query_z     <= q_z;
    end
  end

  assert property (@(posedge clk) disable iff (rst) ref_count <= DEPTH_CNT)
    else $error("reference count beyond depth");

  assert property (@(posedge clk) disable iff (rst) cmd.issue |-> scan_idx < ref_count)
    else $error("scan read beyond stored entries");

  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwritten before delivery");

  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> found && !status.pipe_busy)
    else $error("emit without completed match");

endmodule
`default_nettype wire

// ===== sv/nearest_timestamp_associator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_timestamp_associator
// Stores a reference trajectory and pairs each query pose with the stored
// pose nearest in time, within a configured exclusive gap limit.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    action, stamp, pos_x, pos_y, pos_z
//   out      out_valid / out_ready  ref_stamp, ref_x/y/z, query_stamp, query_x/y/z
//   cfg      cfg_valid / cfg_ready  cfg_data (max_time_gap)
//
// Clear, load and unused actions are handled in the idle state and leave it idle.
// A query is accepted, then the scan issues one memory read per stored entry
// (none on an empty store), leaves the scan state and waits in the drain state
// until the read and compare pipeline has emptied; a match adds an emit state.
// A finished result waits in the output register while the next transaction
// is accepted; a query stalls in its emit state only while out is still full.
// Synchronous reset empties the store and sets max_time_gap to 100000.
// ----------------------------------------------------------------------------
module nearest_timestamp_associator #(
  parameter int unsigned REF_DEPTH = nta_pkg::REF_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [nta_pkg::ACT_W-1:0]           action,
  input  logic [nta_pkg::STAMP_W-1:0]         stamp,
  input  logic signed [nta_pkg::POS_W-1:0]    pos_x,
  input  logic signed [nta_pkg::POS_W-1:0]    pos_y,
  input  logic signed [nta_pkg::POS_W-1:0]    pos_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [nta_pkg::STAMP_W-1:0]         ref_stamp,
  output logic signed [nta_pkg::POS_W-1:0]    ref_x,
  output logic signed [nta_pkg::POS_W-1:0]    ref_y,
  output logic signed [nta_pkg::POS_W-1:0]    ref_z,
  output logic [nta_pkg::STAMP_W-1:0]         query_stamp,
  output logic signed [nta_pkg::POS_W-1:0]    query_x,
  output logic signed [nta_pkg::POS_W-1:0]    query_y,
  output logic signed [nta_pkg::POS_W-1:0]    query_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nta_pkg::GAP_W-1:0]           cfg_data
);
  import nta_pkg::*;

  nta_cmd_t    cmd;
  nta_status_t status;

  assign cfg_ready = 1'b1;

  nta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .status   (status),
    .cmd      (cmd)
  );

  nta_dp #(
    .REF_DEPTH (REF_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .stamp       (stamp),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ref_stamp   (ref_stamp),
    .ref_x       (ref_x),
    .ref_y       (ref_y),
    .ref_z       (ref_z),
    .query_stamp (query_stamp),
    .query_x     (query_x),
    .query_y     (query_y),
    .query_z     (query_z)
  );

endmodule
`default_nettype wire

// ===== sim/tb_nearest_timestamp_associator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_timestamp_associator
// Self-checking bench for the nearest timestamp associator. Drives clear, load,
// query and unused transactions with random idle and stall bursts, predicts every
// matched reference/query pair in a scoreboard and compares each output field
// in order. Directed tests set the gap limit to zero and its maximum; phases rewrite it.
// ----------------------------------------------------------------------------
module tb_nearest_timestamp_associator;
  import nta_pkg::*;

  localparam int unsigned        DEPTH      = REF_DEPTH_DEF;
  localparam logic [ACT_W-1:0]   ACT_UNUSED = 2'd3;
  localparam logic [STAMP_W-1:0] STAMP_MAX  = {STAMP_W{1'b1}};
  localparam logic [STAMP_W-1:0] FAR_STAMP  = 40'h80_0000_0000;
  localparam logic [GAP_W-1:0]   GAP_TOP    = {GAP_W{1'b1}};
  localparam logic [POS_W-1:0]   POS_MIN    = 32'h8000_0000;
  localparam logic [POS_W-1:0]   POS_MAX    = 32'h7FFF_FFFF;
  localparam int unsigned        RAND_ITEMS = 580;
  localparam int unsigned        PHASES     = 6;
  localparam int unsigned        CLEAR_AT   = 48;

  typedef struct packed {
    logic [STAMP_W-1:0] ref_stamp;
    logic [POS_W-1:0]   ref_x;
    logic [POS_W-1:0]   ref_y;
    logic [POS_W-1:0]   ref_z;
    logic [STAMP_W-1:0] query_stamp;
    logic [POS_W-1:0]   query_x;
    logic [POS_W-1:0]   query_y;
    logic [POS_W-1:0]   query_z;
  } pair_t;

  class pair_scoreboard;
    logic [STAMP_W-1:0] times [DEPTH];
    logic [POS_W-1:0]   xs [DEPTH];
    logic [POS_W-1:0]   ys [DEPTH];
    logic [POS_W-1:0]   zs [DEPTH];
    int unsigned        stored;
    logic [GAP_W-1:0]   gap_limit;
    pair_t              pending [$];
    int unsigned        errors;

    function new();
      stored    = 0;
      gap_limit = MAX_GAP_RESET;
      errors    = 0;
    endfunction

    function void set_gap(logic [GAP_W-1:0] v);
      gap_limit = v;
    endfunction

    function void note_input(logic [ACT_W-1:0] act, logic [STAMP_W-1:0] st,
                             logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic [POS_W-1:0] z);
      logic [STAMP_W-1:0] diff;
      logic [STAMP_W-1:0] best_diff;
      int unsigned        best;
      int unsigned        i;
      bit                 found;
      pair_t              hit;
      found     = 1'b0;
      best      = 0;
      best_diff = '0;
      case (act)
        ACT_CLEAR: stored = 0;
        ACT_LOAD: begin
          if (stored < DEPTH) begin
            times[stored] = st;
            xs[stored]    = x;
            ys[stored]    = y;
            zs[stored]    = z;
            stored++;
          end
        end
        ACT_QUERY: begin
          for (i = 0; i < stored; i++) begin
            diff = (st >= times[i]) ? st - times[i] : times[i] - st;
            if (diff < gap_limit && (!found || diff < best_diff)) begin
              best_diff = diff;
              best      = i;
              found     = 1'b1;
            end
          end
          if (found) begin
            hit     = '{times[best], xs[best], ys[best], zs[best], st, x, y, z};
            pending = {pending, hit};
          end
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [STAMP_W-1:0] want,
                              logic [STAMP_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(pair_t got);
      pair_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual ref_stamp %h query_stamp %h",
                 $time, got.ref_stamp, got.query_stamp);
        return;
      end
      want = pending.pop_front();
      check_field("ref_stamp", want.ref_stamp, got.ref_stamp);
      check_field("ref_x", STAMP_W'(want.ref_x), STAMP_W'(got.ref_x));
      check_field("ref_y", STAMP_W'(want.ref_y), STAMP_W'(got.ref_y));
      check_field("ref_z", STAMP_W'(want.ref_z), STAMP_W'(got.ref_z));
      check_field("query_stamp", want.query_stamp, got.query_stamp);
      check_field("query_x", STAMP_W'(want.query_x), STAMP_W'(got.query_x));
      check_field("query_y", STAMP_W'(want.query_y), STAMP_W'(got.query_y));
      check_field("query_z", STAMP_W'(want.query_z), STAMP_W'(got.query_z));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [ACT_W-1:0]         action;
  logic [STAMP_W-1:0]       stamp;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic                     out_valid;
  logic                     out_ready;
  logic [STAMP_W-1:0]       ref_stamp;
  logic signed [POS_W-1:0]  ref_x;
  logic signed [POS_W-1:0]  ref_y;
  logic signed [POS_W-1:0]  ref_z;
  logic [STAMP_W-1:0]       query_stamp;
  logic signed [POS_W-1:0]  query_x;
  logic signed [POS_W-1:0]  query_y;
  logic signed [POS_W-1:0]  query_z;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [GAP_W-1:0]         cfg_data;

  pair_scoreboard           sb;
  bit                       calm = 1'b0;
  longint                   last_base = 0;

  nearest_timestamp_associator u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .stamp       (stamp),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ref_stamp   (ref_stamp),
    .ref_x       (ref_x),
    .ref_y       (ref_y),
    .ref_z       (ref_z),
    .query_stamp (query_stamp),
    .query_x     (query_x),
    .query_y     (query_y),
    .query_z     (query_z),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [STAMP_W-1:0] rand_stamp();
    logic [STAMP_W-1:0] s;
    s[31:0]  = $urandom;
    s[39:32] = 8'($urandom_range(0, 255));
    return s;
  endfunction

  // Grid mode lands stamps on half steps so equal gaps are common.
  function automatic logic [STAMP_W-1:0] near(longint base, bit grid);
    longint      v;
    longint      half;
    int unsigned w;
    half = longint'(sb.gap_limit) / 8 + 1;
    w    = 32'(sb.gap_limit);
    w    = w / 2 * 3 + 2;
    if (grid)
      v = base + half * (longint'($urandom_range(0, 18)) - 9);
    else
      v = base + longint'($urandom_range(0, 2 * w)) - longint'(w);
    if (v < 0)
      v = 0;
    if (v > longint'(STAMP_MAX))
      v = longint'(STAMP_MAX);
    return v[STAMP_W-1:0];
  endfunction

  task automatic send(input logic [ACT_W-1:0] act, input logic [STAMP_W-1:0] st,
                      input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                      input logic [POS_W-1:0] z);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    stamp    <= st;
    pos_x    <= x;
    pos_y    <= y;
    pos_z    <= z;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(act, st, x, y, z);
  endtask

  // Hold until every pair is out, then idle while a query that scans without a match finishes.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (sb.stored + 8) @(posedge clk);
  endtask

  task automatic write_gap(input logic [GAP_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_gap(v);
  endtask

  task automatic random_burst(inout int unsigned sent);
    int unsigned      kind;
    int unsigned      n;
    bit               grid;
    logic [ACT_W-1:0] act;
    kind = $urandom_range(0, 9);
    grid = ($urandom_range(0, 2) == 0);
    if ($urandom_range(0, 39) == 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (sb.pending.size() != 0) @(posedge clk);
    end
    if (kind <= 6) begin
      case ($urandom_range(0, 7))
        0: last_base = $urandom_range(0, 1000);
        1: last_base = longint'(STAMP_MAX) - longint'($urandom_range(0, 1000));
        default: last_base = longint'(rand_stamp());
      endcase
      if (sb.stored > CLEAR_AT || $urandom_range(0, 7) != 0) begin
        send(ACT_CLEAR, rand_stamp(), rand_pos(), rand_pos(), rand_pos());
        sent++;
      end
      n = $urandom_range(1, 16);
      repeat (n) begin
        send(ACT_LOAD, near(last_base, grid), rand_pos(), rand_pos(), rand_pos());
        sent++;
      end
      n = $urandom_range(1, 6);
      repeat (n) begin
        send(ACT_QUERY, near(last_base, grid), rand_pos(), rand_pos(), rand_pos());
        sent++;
      end
    end else if (kind == 7) begin
      act = ACT_W'($urandom_range(0, 3));
      send(act, rand_stamp(), rand_pos(), rand_pos(), rand_pos());
      sent++;
    end else if (kind == 8) begin
      if (sb.stored < CLEAR_AT) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          send(ACT_LOAD, near(last_base, grid), rand_pos(), rand_pos(), rand_pos());
          sent++;
        end
      end
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        send(ACT_QUERY, near(last_base, grid), rand_pos(), rand_pos(), rand_pos());
        sent++;
      end
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid === 1'b1)
        sb.check_result('{ref_stamp, ref_x, ref_y, ref_z,
                          query_stamp, query_x, query_y, query_z});
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned      i;
    int unsigned      ph;
    int unsigned      sent;
    logic [GAP_W-1:0] g;
    sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    action    <= ACT_CLEAR;
    stamp     <= '0;
    pos_x     <= '0;
    pos_y     <= '0;
    pos_z     <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset gap limit, empty store, stamp extremes, ties, limit edge
    send(ACT_QUERY, 40'd1000, 32'd1, 32'd2, 32'd3);
    send(ACT_LOAD, '0, POS_MIN, POS_MIN, POS_MIN);
    send(ACT_LOAD, STAMP_MAX, POS_MAX, POS_MAX, POS_MAX);
    send(ACT_LOAD, 40'd1000, '0, '0, '0);
    send(ACT_LOAD, 40'd1000, 32'hFFFF_FFFF, 32'd1, 32'd2);
    send(ACT_QUERY, 40'd1000, 32'd5, 32'd6, 32'd7);
    send(ACT_QUERY, '0, POS_MAX, POS_MIN, '0);
    send(ACT_QUERY, STAMP_MAX, POS_MIN, POS_MAX, 32'hFFFF_FFFF);
    send(ACT_QUERY, 40'd500, 32'd8, 32'd9, 32'd10);
    send(ACT_QUERY, 40'd101000, 32'd11, 32'd12, 32'd13);
    send(ACT_QUERY, 40'd100999, 32'd14, 32'd15, 32'd16);
    send(ACT_QUERY, STAMP_MAX - 40'd99999, 32'd17, 32'd18, 32'd19);
    send(ACT_UNUSED, 40'd1000, POS_MAX, POS_MAX, POS_MAX);
    send(ACT_QUERY, 40'd1000, 32'd20, 32'd21, 32'd22);
    send(ACT_CLEAR, STAMP_MAX, POS_MAX, POS_MAX, POS_MAX);
    send(ACT_QUERY, 40'd1000, 32'd23, 32'd24, 32'd25);
    send(ACT_LOAD, 40'd2000, 32'd26, 32'd27, 32'd28);
    send(ACT_QUERY, 40'd2000, 32'd29, 32'd30, 32'd31);

    drain();
    write_gap('0);
    send(ACT_LOAD, 40'd5000, 32'd1, 32'd1, 32'd1);
    send(ACT_QUERY, 40'd5000, 32'd2, 32'd2, 32'd2);
    send(ACT_QUERY, 40'd5001, 32'd3, 32'd3, 32'd3);

    drain();
    write_gap(GAP_TOP);
    send(ACT_CLEAR, '0, '0, '0, '0);
    send(ACT_LOAD, 40'd20_000_000, 32'd4, 32'd5, 32'd6);
    send(ACT_QUERY, 40'd36_777_214, 32'd7, 32'd8, 32'd9);
    send(ACT_QUERY, 40'd36_777_215, 32'd10, 32'd11, 32'd12);
    send(ACT_QUERY, 40'd3_222_786, 32'd13, 32'd14, 32'd15);

    // fill the store, then loads past capacity must be dropped
    drain();
    send(ACT_CLEAR, '0, '0, '0, '0);
    for (i = 0; i < DEPTH; i++)
      send(ACT_LOAD, STAMP_W'(i * 1000), rand_pos(), rand_pos(), rand_pos());
    repeat (3) send(ACT_LOAD, FAR_STAMP, rand_pos(), rand_pos(), rand_pos());
    send(ACT_QUERY, FAR_STAMP, rand_pos(), rand_pos(), rand_pos());
    send(ACT_QUERY, 40'd500_500, rand_pos(), rand_pos(), rand_pos());
    send(ACT_QUERY, STAMP_W'((DEPTH - 1) * 1000 + 5), rand_pos(), rand_pos(), rand_pos());
    send(ACT_QUERY, '0, rand_pos(), rand_pos(), rand_pos());
    send(ACT_QUERY, 40'd1_000_000_000, rand_pos(), rand_pos(), rand_pos());

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: g = MAX_GAP_RESET;
        1: g = 24'd1;
        2: g = GAP_TOP;
        3: g = 24'd2000;
        4: g = GAP_W'($urandom_range(0, GAP_TOP));
        default: g = MAX_GAP_RESET;
      endcase
      write_gap(g);
      calm = (ph == PHASES - 1);
      sent = 0;
      while (sent < RAND_ITEMS / PHASES)
        random_burst(sent);
    end

    drain();
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
